// ===== rtl/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_GET        = 3'd0,
    FN_INS_HEAD   = 3'd1,
    FN_INS_TAIL   = 3'd2,
    FN_INS_INDEX  = 3'd3,
    FN_DELETE     = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pls_if.sv =====
`default_nettype none

interface pls_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::FUNC_W-1:0]          func;
  logic signed [pls_pkg::POS_W-1:0]    position;
  logic signed [pls_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface pls_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [pls_pkg::DATA_W-1:0]   read_value;
  logic [pls_pkg::STAT_W-1:0]          status;
  logic [pls_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
`default_nettype none

// Channel  Dir  Payload                                  Accepted when
// cmd_i    in   func, position, item_value               cmd_i.valid && cmd_i.ready
// rsp_o    out  read_value, status, entry_count          rsp_o.valid && rsp_o.ready
//
// Each item gives one result, registered in the read stage and then in the
// output register. An insert or a delete shifts the cells from the addressed
// position upward at the edge that accepts the item. A get reads through a
// registered OR tree in groups of 32 cells. With the result side ready, one
// item is taken per cycle. rst_ni clears the count and the pipeline flags;
// the cells hold whatever they held and only positions below the count are
// ever read. A stalled result holds in the output register, and one more
// item can be taken and held in the read stage behind it.
module positional_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pls_cmd_if.sink    cmd_i,
  pls_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned GS = 32;
  localparam int unsigned NG = (CAPACITY + GS - 1) / GS;
  localparam int unsigned DW = pls_pkg::DATA_W;

  // Number of stored values.
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_d;

  logic          cmd_acc;
  logic          pos_neg;
  logic          pos_ge;
  logic          pos_gt;
  logic          full;
  logic [16:0]   pos_mag;
  logic [16:0]   cnt_ext;
  logic [CW-1:0] pos_idx;

  logic                 do_ins;
  logic                 do_del;
  logic                 rd_hit;
  logic                 rd_miss;
  pls_pkg::status_e     stat;
  logic [CW-1:0]        at;
  pls_pkg::cell_cmd_t   cell_cmd;

  logic [DW-1:0] cell_data [CAPACITY];
  logic [DW-1:0] cell_rd   [CAPACITY];

  // Read stage: per-group ORs plus the decoded result fields.
  logic              s1_valid_q;
  logic [DW-1:0]     grp_q [NG];
  logic [DW-1:0]     grp_d [NG];
  logic              s1_hit_q;
  logic              s1_miss_q;
  pls_pkg::status_e  s1_stat_q;
  logic [CW-1:0]     s1_cnt_q;
  logic              s1_fire;

  // Output register.
  logic              out_valid_q;
  logic [DW-1:0]     out_value_q;
  logic [DW-1:0]     out_value_d;
  pls_pkg::status_e  out_stat_q;
  logic [CW-1:0]     out_cnt_q;

  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !s1_valid_q || s1_fire;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Decode of the incoming item against the current count.
  always_comb begin
    pos_neg = cmd_i.position[16];
    pos_mag = {1'b0, cmd_i.position[15:0]};
    cnt_ext = 17'(cnt_q);
    pos_ge  = !pos_neg && (pos_mag >= cnt_ext);
    pos_gt  = !pos_neg && (pos_mag > cnt_ext);
    full    = (cnt_q == CW'(CAPACITY));
    pos_idx = CW'(cmd_i.position[15:0]);

    do_ins  = 1'b0;
    do_del  = 1'b0;
    rd_hit  = 1'b0;
    rd_miss = 1'b0;
    stat    = pls_pkg::ST_DONE;
    at      = pos_idx;

    case (pls_pkg::func_e'(cmd_i.func))
      pls_pkg::FN_GET: begin
        if (pos_neg || pos_ge) begin
          rd_miss = 1'b1;
          stat    = pls_pkg::ST_RANGE;
        end else begin
          rd_hit = 1'b1;
        end
      end
      pls_pkg::FN_INS_HEAD: begin
        at = '0;
        if (full) begin
          stat = pls_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::FN_INS_TAIL: begin
        at = cnt_q;
        if (full) begin
          stat = pls_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::FN_INS_INDEX: begin
        // A negative position inserts at the head.
        at = pos_neg ? '0 : pos_idx;
        if (pos_gt) begin
          stat = pls_pkg::ST_RANGE;
        end else if (full) begin
          stat = pls_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::FN_DELETE: begin
        if (pos_neg || pos_ge) begin
          stat = pls_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        stat = pls_pkg::ST_RANGE;
      end
    endcase

    cell_cmd.ins = cmd_acc && do_ins;
    cell_cmd.del = cmd_acc && do_del;

    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // The chain of cells. The first cell has no lower neighbor, and that input
  // is never selected; the last has no upper one and takes its own value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] prev_w;
    logic [DW-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = cmd_i.item_value;
    end else begin : g_mid_lo
      assign prev_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = cell_data[i];
    end else begin : g_mid_hi
      assign next_w = cell_data[i+1];
    end

    pls_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .at_i    (at),
      .value_i (cmd_i.item_value),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // First level of the read tree: each cell drives zero unless it is the
  // addressed one, so a group OR yields the addressed value or zero.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GS + k];
        end
      end
    end
  end

  always_comb begin
    out_value_d = '0;
    for (int g = 0; g < NG; g++) begin
      out_value_d = out_value_d | grp_q[g];
    end
    if (s1_miss_q) begin
      out_value_d = '1;
    end else if (!s1_hit_q) begin
      out_value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_acc) begin
        cnt_q <= cnt_d;
      end
      if (cmd_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      grp_q     <= grp_d;
      s1_hit_q  <= rd_hit;
      s1_miss_q <= rd_miss;
      s1_stat_q <= stat;
      s1_cnt_q  <= cnt_d;
    end
    if (s1_fire) begin
      out_value_q <= out_value_d;
      out_stat_q  <= s1_stat_q;
      out_cnt_q   <= s1_cnt_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.entry_count = pls_pkg::COUNT_W'(out_cnt_q);

endmodule

`default_nettype wire

// ===== rtl/pls_cell.sv =====
`default_nettype none

// One list position. On an insert it takes its lower neighbor (or the new
// value at the insert point); on a delete it takes its upper neighbor.
module pls_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire pls_pkg::cell_cmd_t            cmd_i,
  input  wire logic [CW-1:0]                 at_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    value_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    prev_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    next_i,
  output logic      [pls_pkg::DATA_W-1:0]    data_o,
  output logic      [pls_pkg::DATA_W-1:0]    rd_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [pls_pkg::DATA_W-1:0] data_q;
  logic [pls_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyIdx > at_i) begin
        data_d = prev_i;
      end else if (MyIdx == at_i) begin
        data_d = value_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= at_i) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyIdx == at_i) ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/pls_checker.sv =====
`default_nettype none

module pls_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            rsp_valid_i,
  input wire logic                            rsp_ready_i,
  input wire logic [pls_pkg::DATA_W-1:0]      read_value_i,
  input wire logic [pls_pkg::STAT_W-1:0]      status_i,
  input wire logic [pls_pkg::COUNT_W-1:0]     entry_count_i
);

  logic                         seen_q;
  logic [pls_pkg::COUNT_W-1:0]  last_cnt_q;
  logic                         rsp_acc;
  logic                         small_cap;

  assign rsp_acc   = rsp_valid_i && rsp_ready_i;
  assign small_cap = (CAPACITY < 128);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (rsp_acc) begin
      seen_q     <= 1'b1;
      last_cnt_q <= entry_count_i;
    end
  end

  // A refused insert is reported only when the count is at capacity.
  a_full_at_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == pls_pkg::ST_FULL && small_cap
      |-> entry_count_i == pls_pkg::COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  // An error result carries zero, or all ones for a get that misses.
  a_err_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != pls_pkg::ST_DONE
      |-> read_value_i == '0 || read_value_i == '1)
    else $error("error result carries a data value");

  // An ignored or refused item leaves the count as it was.
  a_err_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && seen_q && status_i != pls_pkg::ST_DONE && small_cap
      |-> entry_count_i == last_cnt_q)
    else $error("count changed on an ignored item");

  // Successive results differ in count by at most one.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && seen_q && small_cap
      |-> entry_count_i == last_cnt_q
       || entry_count_i == last_cnt_q + pls_pkg::COUNT_W'(1)
       || entry_count_i == last_cnt_q - pls_pkg::COUNT_W'(1))
    else $error("count jumped by more than one");

  // A stalled result holds.
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i
      |=> rsp_valid_i && $stable(read_value_i) && $stable(status_i)
       && $stable(entry_count_i))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_value_i  (rsp_o.read_value),
  .status_i      (rsp_o.status),
  .entry_count_i (rsp_o.entry_count)
);

`default_nettype wire
